// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks, the top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on i_clk, disabled in reset
`define AST_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication on i_clk, disabled in reset
`define AST_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/sobel_pkg.sv =====
// Shared types, constants and the arctangent table for the Sobel block.
// No dependencies.
package sobel_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LW_W      = 11;
    localparam int ITER_N    = 30;
    localparam int IT_W      = $clog2(ITER_N);
    localparam int SQ_N      = 11;
    localparam int CW        = 38;
    localparam int ZW        = 35;
    localparam logic [ZW-1:0] PI_Q30      = 35'd3373259426;
    localparam logic [14:0]   PI_Q12      = 15'd12868;
    localparam logic [14:0]   HALF_PI_Q12 = 15'd6434;
    localparam logic [LW_W-1:0] LW_RESET  = 11'd640;
    localparam logic [1:0]    REG_LINE_WIDTH = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_LOAD, ST_GRAD, ST_SQR, ST_INIT,
        ST_ITER, ST_PUSH, ST_SHIFT, ST_REPL
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd;
        logic load;
        logic shift;
        logic repl;
        logic grad;
        logic sqr;
        logic init;
        logic iter;
        logic push;
        logic mark_last;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic active;
        logic col0;
        logic last;
        logic iter_last;
        logic iter_done;
        logic out_busy;
    } t_sts;

    function automatic logic [31:0] atan_q30(input logic [IT_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd843314856;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043836;
            5'd3:    v = 32'd133525158;
            5'd4:    v = 32'd67021686;
            5'd5:    v = 32'd33543515;
            5'd6:    v = 32'd16775850;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194282;
            5'd9:    v = 32'd2097149;
            default: v = (32'd1 << (5'd30 - i)) - 32'd1;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/sobel_ctrl.sv =====
// Sequencer for the Sobel block: steps each item through read, window update
// and up to two result computations. Depends on sobel_pkg.
module sobel_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sobel_pkg::t_sts   i_sts,
    output sobel_pkg::t_cmd   o_cmd,
    output logic              o_idle
);

    sobel_pkg::t_state r_state, n_state;
    logic r_second, n_second;
    logic r_emit_b, n_emit_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sobel_pkg::ST_IDLE;
            r_second <= 1'b0;
            r_emit_b <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_emit_b <= n_emit_b;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_emit_b = r_emit_b;
        case (r_state)
            sobel_pkg::ST_IDLE: begin
                if (i_valid) n_state = sobel_pkg::ST_READ;
            end
            sobel_pkg::ST_READ: begin
                n_state = i_sts.drop ? sobel_pkg::ST_IDLE : sobel_pkg::ST_LOAD;
            end
            sobel_pkg::ST_LOAD: begin
                n_emit_b = i_sts.active && i_sts.last;
                n_second = 1'b0;
                if (i_sts.active && !i_sts.col0) begin
                    n_state = sobel_pkg::ST_GRAD;
                end else if (i_sts.active && i_sts.last) begin
                    n_state = sobel_pkg::ST_REPL;
                end else begin
                    n_state = sobel_pkg::ST_IDLE;
                end
            end
            sobel_pkg::ST_GRAD: n_state = sobel_pkg::ST_SQR;
            sobel_pkg::ST_SQR:  n_state = sobel_pkg::ST_INIT;
            sobel_pkg::ST_INIT: n_state = sobel_pkg::ST_ITER;
            sobel_pkg::ST_ITER: begin
                if (i_sts.iter_last) n_state = sobel_pkg::ST_PUSH;
            end
            sobel_pkg::ST_PUSH: begin
                if (!i_sts.out_busy) begin
                    n_state = r_second ? sobel_pkg::ST_IDLE : sobel_pkg::ST_SHIFT;
                end
            end
            sobel_pkg::ST_SHIFT: begin
                n_state = r_emit_b ? sobel_pkg::ST_REPL : sobel_pkg::ST_IDLE;
            end
            sobel_pkg::ST_REPL: begin
                n_second = 1'b1;
                n_state  = sobel_pkg::ST_GRAD;
            end
            default: n_state = sobel_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        case (r_state)
            sobel_pkg::ST_IDLE: begin
                o_idle        = 1'b1;
                o_cmd.capture = i_valid;
            end
            sobel_pkg::ST_READ:  o_cmd.rd    = !i_sts.drop;
            sobel_pkg::ST_LOAD:  o_cmd.load  = 1'b1;
            sobel_pkg::ST_GRAD:  o_cmd.grad  = 1'b1;
            sobel_pkg::ST_SQR:   o_cmd.sqr   = 1'b1;
            sobel_pkg::ST_INIT:  o_cmd.init  = 1'b1;
            sobel_pkg::ST_ITER:  o_cmd.iter  = 1'b1;
            sobel_pkg::ST_PUSH: begin
                o_cmd.push      = !i_sts.out_busy;
                o_cmd.mark_last = r_second;
            end
            sobel_pkg::ST_SHIFT: o_cmd.shift = 1'b1;
            sobel_pkg::ST_REPL:  o_cmd.repl  = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/sobel_dp.sv =====
// Sobel datapath: line stores, 3x3 window, gradients, iterative square root
// and CORDIC arctangent, output register. Depends on sobel_pkg.
module sobel_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sobel_pkg::t_cmd              i_cmd,
    output sobel_pkg::t_sts              o_sts,
    input  logic [sobel_pkg::LW_W-1:0]   i_line_width,
    input  logic                         i_mode,
    input  logic [7:0]                   i_pixel,
    input  logic                         i_frame_start,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [10:0]           o_grad_x,
    output logic signed [10:0]           o_grad_y,
    output logic [10:0]                  o_magnitude,
    output logic signed [14:0]           o_direction,
    output logic                         o_frame_last
);

    logic [7:0] row_above     [sobel_pkg::MAX_WIDTH];
    logic [7:0] row_two_above [sobel_pkg::MAX_WIDTH];

    logic [sobel_pkg::COL_W-1:0] r_col;
    logic [1:0]                  r_rows;
    logic                        r_mode;
    logic [7:0]                  r_pix;
    logic [7:0]                  r_a, r_b;
    logic [7:0]                  r_win [9];

    logic signed [10:0] r_gx, r_gy;
    logic [20:0]        r_sqx, r_sqy;
    logic [21:0]        r_sv, r_sr, r_sb;
    logic signed [sobel_pkg::CW-1:0] r_x, r_y;
    logic signed [sobel_pkg::ZW-1:0] r_z;
    logic [sobel_pkg::IT_W-1:0] r_it;
    logic               r_done;
    logic               r_ovalid;

    logic [sobel_pkg::LW_W-1:0] eff;
    logic                       last;
    logic [7:0]                 top, bot;
    logic signed [12:0]         gx_w, gy_w;
    logic signed [sobel_pkg::CW-1:0] xs, ys;
    logic signed [sobel_pkg::ZW-1:0] at;
    logic [22:0]                strial;
    logic [9:0]                 ax, ay;
    logic signed [sobel_pkg::ZW-1:0] zc;
    logic [sobel_pkg::ZW-1:0]   zr;
    logic [14:0]                d;
    logic signed [14:0]         dir;

    always_comb begin
        if (i_line_width == '0) begin
            eff = sobel_pkg::LW_W'(1);
        end else if (i_line_width > sobel_pkg::LW_W'(sobel_pkg::MAX_WIDTH)) begin
            eff = sobel_pkg::LW_W'(sobel_pkg::MAX_WIDTH);
        end else begin
            eff = i_line_width;
        end
        last = (sobel_pkg::LW_W'(r_col) + sobel_pkg::LW_W'(1)) >= eff;
        top  = (r_rows >= 2'd2) ? r_b : r_a;
        bot  = r_mode ? r_a : r_pix;
    end

    assign o_sts.drop      = r_mode && (r_rows == 2'd0);
    assign o_sts.active    = r_rows != 2'd0;
    assign o_sts.col0      = r_col == '0;
    assign o_sts.last      = last;
    assign o_sts.iter_last = r_it == sobel_pkg::IT_W'(sobel_pkg::ITER_N - 1);
    assign o_sts.iter_done = r_done;
    assign o_sts.out_busy  = r_ovalid && i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_a <= row_above[r_col];
            r_b <= row_two_above[r_col];
        end
        if (i_cmd.load) begin
            row_two_above[r_col] <= r_a;
            row_above[r_col]     <= bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rows <= '0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            if (i_cmd.capture && !i_mode && i_frame_start) begin
                r_col  <= '0;
                r_rows <= '0;
            end
            if (i_cmd.load) begin
                if (last) begin
                    r_col <= '0;
                    if (r_mode) begin
                        r_rows <= '0;
                    end else if (r_rows < 2'd2) begin
                        r_rows <= r_rows + 2'd1;
                    end
                end else begin
                    r_col <= r_col + sobel_pkg::COL_W'(1);
                end
                if (r_rows != 2'd0) begin
                    if (r_col == '0) begin
                        for (int k = 0; k < 3; k++) begin
                            r_win[k]     <= top;
                            r_win[3 + k] <= r_a;
                            r_win[6 + k] <= bot;
                        end
                    end else begin
                        r_win[2] <= top;
                        r_win[5] <= r_a;
                        r_win[8] <= bot;
                    end
                end
            end
            if (i_cmd.shift) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k * 3]     <= r_win[k * 3 + 1];
                    r_win[k * 3 + 1] <= r_win[k * 3 + 2];
                end
            end
            if (i_cmd.repl) begin
                for (int k = 0; k < 3; k++) r_win[k * 3 + 2] <= r_win[k * 3 + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_pix  <= i_pixel;
        end
    end

    always_comb begin
        gx_w = ($signed({5'b0, r_win[2]}) + $signed({4'b0, r_win[5], 1'b0})
              + $signed({5'b0, r_win[8]}))
             - ($signed({5'b0, r_win[0]}) + $signed({4'b0, r_win[3], 1'b0})
              + $signed({5'b0, r_win[6]}));
        gy_w = ($signed({5'b0, r_win[6]}) + $signed({4'b0, r_win[7], 1'b0})
              + $signed({5'b0, r_win[8]}))
             - ($signed({5'b0, r_win[0]}) + $signed({4'b0, r_win[1], 1'b0})
              + $signed({5'b0, r_win[2]}));
        ax = r_gx[10] ? 10'(-r_gx) : r_gx[9:0];
        ay = r_gy[10] ? 10'(-r_gy) : r_gy[9:0];
        xs = r_x >>> r_it;
        ys = r_y >>> r_it;
        at = $signed({3'b0, sobel_pkg::atan_q30(r_it)});
        strial = {1'b0, r_sr} + {1'b0, r_sb};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_gx <= 11'(gx_w);
            r_gy <= 11'(gy_w);
        end
        if (i_cmd.sqr) begin
            r_sqx <= 21'(unsigned'(22'(r_gx * r_gx)));
            r_sqy <= 21'(unsigned'(22'(r_gy * r_gy)));
        end
        if (i_cmd.init) begin
            r_sv <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_sr <= '0;
            r_sb <= 22'd1 << 20;
            r_x  <= $signed({4'b0, ax, 24'b0});
            r_y  <= $signed({4'b0, ay, 24'b0});
            r_z  <= '0;
            r_it <= '0;
        end
        if (i_cmd.iter) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
            if (r_it < sobel_pkg::IT_W'(sobel_pkg::SQ_N)) begin
                if ({1'b0, r_sv} >= strial) begin
                    r_sv <= r_sv - strial[21:0];
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            r_it <= r_it + sobel_pkg::IT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_cmd.init) begin
            r_done <= 1'b0;
        end else if (i_cmd.iter && o_sts.iter_last) begin
            r_done <= 1'b1;
        end
    end

    always_comb begin
        zc = (r_z < 0) ? '0 : r_z;
        if (r_gx[10]) zc = $signed(sobel_pkg::PI_Q30) - zc;
        zr = unsigned'(zc) + sobel_pkg::ZW'(131072);
        d  = zr[32:18];
        if (r_gy == '0) begin
            dir = r_gx[10] ? $signed(sobel_pkg::PI_Q12) : '0;
        end else if (r_gx == '0) begin
            dir = r_gy[10] ? -$signed(sobel_pkg::HALF_PI_Q12)
                           : $signed(sobel_pkg::HALF_PI_Q12);
        end else begin
            dir = r_gy[10] ? -$signed(d) : $signed(d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.push) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_grad_x     <= r_gx;
            o_grad_y     <= r_gy;
            o_magnitude  <= r_sr[10:0];
            o_direction  <= dir;
            o_frame_last <= i_cmd.mark_last && r_mode;
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ===== rtl/core/sobel_gradient_magnitude_direction_top.sv =====
// Top level of the Sobel gradient block: configuration register, sequencer
// and datapath. Depends on sobel_pkg, sobel_ctrl, sobel_dp, assert_macros.svh.
//
//   channel  | direction | handshake        | payload
//   input    | in        | i_valid/o_stall  | mode, pixel, frame_start
//   output   | out       | o_valid/i_stall  | grad_x, grad_y, magnitude,
//            |           |                  | direction, frame_last
//   config   | in        | APB psel/penable | line_width at address 0
//
// A pixel item passes read and load, a dropped flush read only; each result
// adds gradient, square, setup, the 30-step shared CORDIC/root loop and push.
// A new item is taken only when the previous one has finished.
// The output register holds a result under stall; the sequencer waits in
// its push step until the register is free. Reset is synchronous, active low.
module sobel_gradient_magnitude_direction_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [7:0]         i_pixel,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [10:0] o_grad_x,
    output logic signed [10:0] o_grad_y,
    output logic [10:0]        o_magnitude,
    output logic signed [14:0] o_direction,
    output logic               o_frame_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "assert_macros.svh"

    sobel_pkg::t_cmd cmd;
    sobel_pkg::t_sts sts;
    logic            idle;
    logic [sobel_pkg::LW_W-1:0] r_line_width;

    assign pready  = 1'b1;
    assign prdata  = {21'b0, r_line_width};
    assign o_stall = !idle || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= sobel_pkg::LW_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == sobel_pkg::REG_LINE_WIDTH)) begin
            r_line_width <= pwdata[sobel_pkg::LW_W-1:0];
        end
    end

    sobel_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    sobel_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_line_width  (r_line_width),
        .i_mode        (i_mode),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_grad_x      (o_grad_x),
        .o_grad_y      (o_grad_y),
        .o_magnitude   (o_magnitude),
        .o_direction   (o_direction),
        .o_frame_last  (o_frame_last)
    );

    `AST_IMP(a_push_free, cmd.push, !(o_valid && i_stall))
    `AST_IMP(a_push_done, cmd.push, sts.iter_done)
    `AST_IMP(a_idle_quiet, !o_stall, !cmd.iter && !cmd.push)
    `AST_NXT(a_push_shows, cmd.push, o_valid)

endmodule

// ===== bench/sobel_gradient_magnitude_direction_top_tb.sv =====
// Self-checking bench for the Sobel gradient block: predicts gradients, magnitude,
// direction and frame end for every transfer, and compares them in order.
// Depends on sobel_pkg and sobel_gradient_magnitude_direction_top.
module sobel_gradient_magnitude_direction_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       MODE_PIXEL     = 1'b0;
    localparam logic       MODE_FLUSH     = 1'b1;
    localparam int         DRAIN_CYCLES   = 120;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel;
        logic       frame_start;
    } t_pixel_item;

    typedef struct packed {
        logic signed [10:0] grad_x;
        logic signed [10:0] grad_y;
        logic [10:0]        magnitude;
        logic signed [14:0] direction;
        logic               frame_last;
    } t_grad_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_mode = 1'b0;
    logic [7:0]         i_pixel = 8'd0;
    logic               i_frame_start = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [10:0] o_grad_x;
    logic signed [10:0] o_grad_y;
    logic [10:0]        o_magnitude;
    logic signed [14:0] o_direction;
    logic               o_frame_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [1:0]         paddr = 2'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    sobel_gradient_magnitude_direction_top DUT (.*);

    always #5 i_clk = ~i_clk;

    t_pixel_item  pixel_queue[$];
    t_grad_result grad_expected[$];
    logic [7:0]   line_prev[sobel_pkg::MAX_WIDTH];
    logic [7:0]   line_prev2[sobel_pkg::MAX_WIDTH];
    logic [7:0]   win[9];
    int unsigned  col_pos;
    int unsigned  row_count;
    logic [10:0]  width_reg;
    logic         took = 1'b0;
    logic         no_idle = 1'b0;
    logic         hold_off = 1'b0;
    int           fails = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           frames_sent = 0;

    function automatic longint arctan_step(int i);
        longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10) return head[i];
        return (longint'(1) << (30 - i)) - 1;
    endfunction

    function automatic logic [10:0] root_floor(int unsigned v);
        int unsigned r;
        int unsigned b;
        r = 0;
        b = 32'd1 << 30;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[10:0];
    endfunction

    function automatic logic signed [14:0] angle_q12(int gx, int gy);
        longint x, y, z, nx, ny, d;
        if (gy == 0) return (gx >= 0) ? 15'sd0 : sobel_pkg::PI_Q12;
        if (gx == 0) return (gy > 0) ? sobel_pkg::HALF_PI_Q12 : -sobel_pkg::HALF_PI_Q12;
        x = longint'(gx < 0 ? -gx : gx) <<< 24;
        y = longint'(gy < 0 ? -gy : gy) <<< 24;
        z = 0;
        for (int i = 0; i < 30; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + arctan_step(i);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - arctan_step(i);
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (gx < 0) z = 64'sd3373259426 - z;
        d = (z + 131072) >>> 18;
        return (gy < 0) ? -d[14:0] : d[14:0];
    endfunction

    task automatic push_gradient(logic is_last);
        int gx, gy;
        t_grad_result r;
        gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
        gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        r.grad_x     = gx[10:0];
        r.grad_y     = gy[10:0];
        r.magnitude  = root_floor(gx * gx + gy * gy);
        r.direction  = angle_q12(gx, gy);
        r.frame_last = is_last;
        grad_expected.insert(grad_expected.size(), r);
    endtask

    task automatic sobel_predict(t_pixel_item it);
        int unsigned eff, c;
        logic [7:0] a, b, top, mid, bot;
        logic is_last, flush;
        flush = (it.mode == MODE_FLUSH);
        eff = width_reg;
        if (eff < 1) eff = 1;
        if (eff > sobel_pkg::MAX_WIDTH) eff = sobel_pkg::MAX_WIDTH;
        if (!flush && it.frame_start) begin
            col_pos = 0;
            row_count = 0;
        end
        if (flush && row_count == 0) return;
        if (col_pos >= sobel_pkg::MAX_WIDTH) col_pos = 0;
        c = col_pos;
        a = line_prev[c];
        b = line_prev2[c];
        bot = flush ? a : it.pixel;
        mid = a;
        top = (row_count >= 2) ? b : a;
        line_prev2[c] = a;
        line_prev[c] = bot;
        is_last = (c + 1 >= eff);
        if (row_count > 0) begin
            if (c == 0) begin
                for (int r = 0; r < 3; r++) begin
                    win[r] = top;
                    win[3 + r] = mid;
                    win[6 + r] = bot;
                end
            end else begin
                win[2] = top;
                win[5] = mid;
                win[8] = bot;
                push_gradient(1'b0);
                for (int r = 0; r < 3; r++) begin
                    win[r * 3] = win[r * 3 + 1];
                    win[r * 3 + 1] = win[r * 3 + 2];
                end
            end
            if (is_last) begin
                for (int r = 0; r < 3; r++) win[r * 3 + 2] = win[r * 3 + 1];
                push_gradient(flush);
            end
        end
        if (is_last) begin
            col_pos = 0;
            if (flush) row_count = 0;
            else if (row_count < 2) row_count++;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        took <= i_rst_n && i_valid && !o_stall;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (took) begin
                sobel_predict(pixel_queue.pop_front());
                items_sent++;
            end
            if (i_valid && !took) begin
                i_valid <= 1'b1;
            end else if (pixel_queue.size() > 0 && !hold_off
                         && (no_idle || $urandom_range(0, 99) >= 18)) begin
                i_valid       <= 1'b1;
                i_mode        <= pixel_queue[0].mode;
                i_pixel       <= pixel_queue[0].pixel;
                i_frame_start <= pixel_queue[0].frame_start;
            end else begin
                i_valid <= 1'b0;
            end
            i_stall <= !no_idle && ($urandom_range(0, 99) < 18);
        end
    end

    always @(posedge i_clk) begin
        t_grad_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (grad_expected.size() == 0) begin
                $error("unexpected result gx=%0d gy=%0d", o_grad_x, o_grad_y);
                fails++;
            end else begin
                e = grad_expected.pop_front();
                if (o_grad_x !== e.grad_x) begin
                    $error("grad_x expected %0d actual %0d", e.grad_x, o_grad_x);
                    fails++;
                end
                if (o_grad_y !== e.grad_y) begin
                    $error("grad_y expected %0d actual %0d", e.grad_y, o_grad_y);
                    fails++;
                end
                if (o_magnitude !== e.magnitude) begin
                    $error("magnitude expected %0d actual %0d", e.magnitude, o_magnitude);
                    fails++;
                end
                if (o_direction !== e.direction) begin
                    $error("direction expected %0d actual %0d", e.direction, o_direction);
                    fails++;
                end
                if (o_frame_last !== e.frame_last) begin
                    $error("frame_last expected %0b actual %0b", e.frame_last, o_frame_last);
                    fails++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || i_valid || took || grad_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_width(logic [10:0] w);
        wait_idle();
        @(negedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= sobel_pkg::REG_LINE_WIDTH;
        pwdata <= {21'd0, w};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        width_reg = w;
    endtask

    function automatic logic [7:0] rand_pixel();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_item(logic mode, logic [7:0] pix, logic fs);
        t_pixel_item it;
        it.mode = mode;
        it.pixel = pix;
        it.frame_start = fs;
        pixel_queue.insert(pixel_queue.size(), it);
    endtask

    // noisy frames drop in stray flushes, restarts and flag bits
    task automatic add_frame(int w, int rows, bit noisy);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < w; c++) begin
                if (noisy && (r != 0 || c != 0) && $urandom_range(0, 39) == 0)
                    add_item(MODE_FLUSH, rand_pixel(), 1'($urandom));
                else
                    add_item(MODE_PIXEL, rand_pixel(),
                             (r == 0 && c == 0) || (noisy && $urandom_range(0, 99) == 0));
            end
        for (int c = 0; c < w; c++)
            add_item(MODE_FLUSH, rand_pixel(), noisy ? 1'($urandom) : 1'b0);
        frames_sent++;
    endtask

    initial begin
        int w, rows;
        logic [10:0] reg_w;
        col_pos = 0;
        row_count = 0;
        width_reg = sobel_pkg::LW_RESET;
        foreach (win[i]) win[i] = 8'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored flush, sharp edges at width 3, single pixel rows
        write_line_width(11'd3);
        add_item(MODE_FLUSH, 8'd255, 1'b1);
        add_item(MODE_PIXEL, 8'd0, 1'b1);
        add_item(MODE_PIXEL, 8'd0, 1'b0);
        add_item(MODE_PIXEL, 8'd255, 1'b0);
        add_item(MODE_PIXEL, 8'd255, 1'b0);
        add_item(MODE_PIXEL, 8'd0, 1'b0);
        add_item(MODE_PIXEL, 8'd0, 1'b0);
        add_item(MODE_FLUSH, 8'd0, 1'b1);
        add_item(MODE_PIXEL, 8'd0, 1'b0);
        add_item(MODE_FLUSH, 8'd0, 1'b0);
        add_item(MODE_FLUSH, 8'd0, 1'b0);
        add_item(MODE_PIXEL, 8'd255, 1'b1);
        add_item(MODE_FLUSH, 8'd0, 1'b0);
        add_item(MODE_FLUSH, 8'd0, 1'b0);
        add_item(MODE_FLUSH, 8'd0, 1'b0);
        write_line_width(11'd1);
        add_item(MODE_PIXEL, 8'd255, 1'b1);
        add_item(MODE_PIXEL, 8'd0, 1'b0);
        add_item(MODE_FLUSH, 8'd7, 1'b1);
        write_line_width(11'd0);
        add_item(MODE_PIXEL, 8'd128, 1'b1);
        add_item(MODE_FLUSH, 8'd0, 1'b0);

        while (items_sent + pixel_queue.size() < 1050) begin
            if ($urandom_range(0, 2) == 0) begin
                reg_w = $urandom_range(0, 5) == 0 ? 11'd0 : 11'($urandom_range(1, 8));
                if ($urandom_range(0, 9) == 0) reg_w = 11'($urandom_range(9, 40));
                write_line_width(reg_w);
            end
            w = (width_reg == 0) ? 1 : width_reg;
            rows = $urandom_range(1, 4);
            no_idle = (frames_sent % 40) >= 30;
            add_frame(w, rows, $urandom_range(0, 3) == 0);
            if (frames_sent == 20) begin
                hold_off = 1'b1;
                while (grad_expected.size() > 0 || took || i_valid) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end
        no_idle = 1'b0;
        wait_idle();

        $display("Covered %0d transfers in %0d frames, %0d results checked,",
                 items_sent, frames_sent, results_seen);
        $display("line widths from 0 through 40 with idle and stall on both sides.");
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sobel_pkg.sv
rtl/core/sobel_ctrl.sv
rtl/core/sobel_dp.sv
rtl/core/sobel_gradient_magnitude_direction_top.sv
bench/sobel_gradient_magnitude_direction_top_tb.sv
